// ===== rtl/itrd_pkg.sv =====
// shared types, constants and helper functions for the radix text converter
package itrd_pkg;

	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(DATA_W);
	localparam int MAX_SYMBOLS = 16;
	localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
	localparam int RADIX_W     = DIGIT_W + 1;
	localparam int MAX_DIGITS  = DATA_W;
	localparam int NDIG_W      = $clog2(MAX_DIGITS) + 1;
	localparam int CHAR_W      = 8;
	localparam int CFG_W       = 64;
	localparam int COUNT_W     = 5;
	localparam int IDX_W       = 2;

	localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'h2D;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RST = 5'd2;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// clamp the symbol count into the legal radix range
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [COUNT_W-1:0] sc);
		logic [RADIX_W-1:0] r;
		if (sc < COUNT_W'(2)) begin
			r = RADIX_W'(2);
		end else if (sc > COUNT_W'(MAX_SYMBOLS)) begin
			r = RADIX_W'(MAX_SYMBOLS);
		end else begin
			r = RADIX_W'(sc);
		end
		return r;
	endfunction

	// alphabet lookup, eight symbols per word
	function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] w;
		w = d[DIGIT_W-1] ? hi : lo;
		return w[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage

// ===== rtl/itrd_div.sv =====
// bit-serial restoring divider, 32-bit dividend by a small radix
module itrd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [itrd_pkg::DATA_W-1:0]         dividend,
	input  logic [itrd_pkg::RADIX_W-1:0]        divisor,
	output itrd_pkg::div_stat_t                 stat,
	output logic [itrd_pkg::DATA_W-1:0]         quotient,
	output logic [itrd_pkg::DIGIT_W-1:0]        remainder
);

	logic [itrd_pkg::DATA_W-1:0]  quo_q;
	logic [itrd_pkg::DIGIT_W-1:0] rem_q;
	logic [itrd_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [itrd_pkg::RADIX_W-1:0] trial;
	logic                         fits;
	logic [itrd_pkg::RADIX_W-1:0] diff;

	// remainder stays below the radix, so it fits in a digit
	assign trial = {rem_q, quo_q[itrd_pkg::DATA_W-1]};
	assign fits  = trial >= divisor;
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {itrd_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[itrd_pkg::DATA_W-2:0], fits};
			rem_q <= fits ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/int_to_radix_digit_string.sv =====
// top level: signed integer to text in a configured radix and alphabet
//
// input channel: value_valid / value_ready carry one signed 32-bit item.
// output channel: result_valid / result_ready carry one character per item,
// with last set on the final character of that value's text.
// config port: cfg_we writes cfg_data into register cfg_index (0 symbol
// count, 1 symbols 0..7, 2 symbols 8..15); other indexes are dropped.
// a negative value first gives '-', then its magnitude's digits, most
// significant first. digits come from a shared bit-serial divider that
// runs one pass of 32 restoring steps per digit.
// once all digits are in, characters go out one per cycle while the
// receiver keeps result_ready high. value_ready is high only while the
// sequencer is idle, so a new item is taken only after the previous one's
// last character has entered the output register.
// a stalled receiver simply freezes the output register and the emit
// sequence; nothing is dropped.
// reset: symbol count returns to 2, alphabet to all zero bytes, sequencer
// to idle with no result pending.
module int_to_radix_digit_string (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                value_valid,
	output logic                                value_ready,
	input  logic signed [itrd_pkg::DATA_W-1:0]  value,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [itrd_pkg::CHAR_W-1:0]         character,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [itrd_pkg::IDX_W-1:0]          cfg_index,
	input  logic [itrd_pkg::CFG_W-1:0]          cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_SIGN  = 4'b0100,
		ST_DIGIT = 4'b1000
	} state_t;

	state_t                              state_q;
	logic [itrd_pkg::COUNT_W-1:0]        symbol_count_q;
	logic [itrd_pkg::CFG_W-1:0]          symbols_low_q;
	logic [itrd_pkg::CFG_W-1:0]          symbols_high_q;
	logic [itrd_pkg::RADIX_W-1:0]        radix_q;
	logic                                neg_q;
	logic [itrd_pkg::NDIG_W-1:0]         ndig_q;
	logic [itrd_pkg::DIGIT_W-1:0]        digits_q [itrd_pkg::MAX_DIGITS];
	logic                                result_valid_q;
	logic [itrd_pkg::CHAR_W-1:0]         character_q;
	logic                                last_q;

	logic                                accept;
	logic                                out_free;
	logic                                div_start;
	logic [itrd_pkg::DATA_W-1:0]         div_dividend;
	logic [itrd_pkg::DATA_W-1:0]         mag;
	logic [itrd_pkg::RADIX_W-1:0]        radix_in;
	itrd_pkg::div_stat_t                 div_stat;
	logic [itrd_pkg::DATA_W-1:0]         div_quo;
	logic [itrd_pkg::DIGIT_W-1:0]        div_rem;
	logic [itrd_pkg::NDIG_W-1:0]         rd_ptr;
	logic                                more_digits;

	assign value_ready = (state_q == ST_IDLE);
	assign accept      = value_valid && value_ready;
	assign out_free    = !result_valid_q || result_ready;

	// magnitude at full width, so the most negative value works out
	assign mag      = value[itrd_pkg::DATA_W-1] ? (32'd0 - value) : value;
	assign radix_in = itrd_pkg::eff_radix(symbol_count_q);

	// next division pass: from a fresh item or from the last quotient
	assign more_digits  = (state_q == ST_DIV) && div_stat.done && (div_quo != '0);
	assign div_start    = accept || more_digits;
	assign div_dividend = accept ? mag : div_quo;
	assign rd_ptr       = ndig_q - 1'b1;

	itrd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (accept ? radix_in : radix_q),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= itrd_pkg::SYMBOL_COUNT_RST;
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				itrd_pkg::REG_SYMBOL_COUNT: symbol_count_q <= cfg_data[itrd_pkg::COUNT_W-1:0];
				itrd_pkg::REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
				itrd_pkg::REG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ndig_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ndig_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						ndig_q <= ndig_q + 1'b1;
						if (div_quo == '0) begin
							state_q <= neg_q ? ST_SIGN : ST_DIGIT;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_free) begin
						ndig_q <= ndig_q - 1'b1;
						if (ndig_q == itrd_pkg::NDIG_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-item payload and digit stack
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= value[itrd_pkg::DATA_W-1];
			radix_q <= radix_in;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			digits_q[ndig_q[itrd_pkg::NDIG_W-2:0]] <= div_rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= (state_q == ST_SIGN) || (state_q == ST_DIGIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_SIGN) begin
				character_q <= itrd_pkg::MINUS_SIGN;
				last_q      <= 1'b0;
			end else begin
				character_q <= itrd_pkg::symbol_of(digits_q[rd_ptr[itrd_pkg::NDIG_W-2:0]],
					symbols_low_q, symbols_high_q);
				last_q      <= (ndig_q == itrd_pkg::NDIG_W'(1));
			end
		end
	end

	assign result_valid = result_valid_q;
	assign character    = character_q;
	assign last         = last_q;

`ifndef SYNTH
	a_digit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (ndig_q != '0))
		else $error("digit emit with empty digit stack");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DIV) && div_stat.busy)
		else $error("accepted item did not start the divider");

	a_ndig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= itrd_pkg::NDIG_W'(itrd_pkg::MAX_DIGITS))
		else $error("digit count overflow");
`endif

endmodule

// ===== sim/tb_int_to_radix_digit_string.sv =====
`timescale 1ns / 1ps
// testbench for the radix text converter: directed and random values checked per character
module tb_int_to_radix_digit_string;

	// index 3 decodes to no register, writes there must be dropped
	localparam logic [itrd_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
	// plain hex alphabet, symbol k in byte k
	localparam logic [itrd_pkg::CFG_W-1:0] HEX_LO = 64'h3736353433323130;
	localparam logic [itrd_pkg::CFG_W-1:0] HEX_HI = 64'h6665646362613938;
	localparam logic [itrd_pkg::DATA_W-1:0] MOST_NEG = 32'h80000000;
	localparam logic [itrd_pkg::DATA_W-1:0] MOST_POS = 32'h7fffffff;
	localparam int TAIL_CYCLES   = 40;
	// worst quiet stretch is a full radix-two conversion plus a long gap
	localparam int QUIET_LIMIT   = 12000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 17;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		logic [itrd_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} text_char_t;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               value_valid  = 1'b0;
	logic                               value_ready;
	logic signed [itrd_pkg::DATA_W-1:0] value        = '0;
	logic                               result_valid;
	logic                               result_ready = 1'b0;
	logic [itrd_pkg::CHAR_W-1:0]        character;
	logic                               last;
	logic                               cfg_we       = 1'b0;
	logic [itrd_pkg::IDX_W-1:0]         cfg_index    = '0;
	logic [itrd_pkg::CFG_W-1:0]         cfg_data     = '0;

	// our own copy of the register file
	logic [itrd_pkg::COUNT_W-1:0] sym_count = itrd_pkg::SYMBOL_COUNT_RST;
	logic [itrd_pkg::CFG_W-1:0]   alpha_lo  = '0;
	logic [itrd_pkg::CFG_W-1:0]   alpha_hi  = '0;

	logic signed [itrd_pkg::DATA_W-1:0] pending_values[$];
	text_char_t                         expected_text[$];

	// steady phases run with no gaps and no stalls
	logic steady        = 1'b0;
	int   gap_left      = 0;
	int   stall_left    = 0;
	int   quiet_cycles  = 0;
	int   values_sent   = 0;
	int   chars_seen    = 0;
	int   mismatches    = 0;
	int   settings_used = 0;

	int_to_radix_digit_string u_top (.*);

	always #6 clk = ~clk;

	// symbol count clamped into 2..MAX_SYMBOLS
	function automatic logic [31:0] radix_now();
		logic [31:0] r;
		r = 32'(sym_count);
		if (r < 32'd2) begin
			r = 32'd2;
		end else if (r > 32'(itrd_pkg::MAX_SYMBOLS)) begin
			r = 32'(itrd_pkg::MAX_SYMBOLS);
		end
		return r;
	endfunction

	// digit to alphabet byte
	function automatic logic [itrd_pkg::CHAR_W-1:0] glyph(input logic [31:0] d);
		logic [itrd_pkg::CFG_W-1:0] word;
		word = (d < 32'd8) ? alpha_lo : alpha_hi;
		return word[(d % 8) * 8 +: 8];
	endfunction

	// expected characters of one value: optional sign, then digits msb first
	function automatic void predict_text(input logic [itrd_pkg::DATA_W-1:0] raw);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [31:0] digits[$];
		text_char_t  c;
		radix = radix_now();
		// two's complement negate keeps the most negative value exact
		mag = raw[itrd_pkg::DATA_W-1] ? (32'd0 - raw) : raw;
		do begin
			digits.push_front(mag % radix);
			mag = mag / radix;
		end while (mag != 32'd0);
		if (raw[itrd_pkg::DATA_W-1]) begin
			c.ch   = itrd_pkg::MINUS_SIGN;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		foreach (digits[i]) begin
			c.ch   = glyph(digits[i]);
			c.last = (i == digits.size() - 1);
			expected_text.push_back(c);
		end
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 24);
		end
		return $urandom_range(60, 200);
	endfunction

	// random value: full range, small magnitudes, radix powers and extremes
	function automatic logic [itrd_pkg::DATA_W-1:0] pick_value();
		logic [63:0] p;
		logic [31:0] v;
		int          sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: begin
				v = $urandom;
			end
			4: begin
				v = $urandom_range(0, 40);
			end
			5: begin
				v = 32'd0 - 32'($urandom_range(1, 40));
			end
			6, 7: begin
				// a power of the radix or one below, where digit count changes
				p = 64'd1;
				repeat ($urandom_range(1, 31)) begin
					if (p * radix_now() <= 64'hffffffff) begin
						p = p * radix_now();
					end
				end
				v = p[31:0] - 32'($urandom_range(0, 1));
				if ($urandom_range(0, 1) == 1) begin
					v = 32'd0 - v;
				end
			end
			8: begin
				case ($urandom_range(0, 3))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = 32'd0;
					default: v = 32'hffffffff;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1) begin
					v = 32'd0 - v;
				end
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		mismatches++;
	endtask

	// one register write, mirrored into the predictor's copy
	task automatic write_reg(input logic [itrd_pkg::IDX_W-1:0] idx,
			input logic [itrd_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			itrd_pkg::REG_SYMBOL_COUNT: sym_count = data[itrd_pkg::COUNT_W-1:0];
			itrd_pkg::REG_SYMBOLS_LOW:  alpha_lo  = data;
			itrd_pkg::REG_SYMBOLS_HIGH: alpha_hi  = data;
			default: ;
		endcase
	endtask

	// wait until every queued value is sent and every character has come back
	task automatic settle();
		do begin
			@(negedge clk);
		end while (pending_values.size() != 0 || value_valid || expected_text.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// input side: feeds queued values, predicts on acceptance
	always @(posedge clk) begin : drive_values
		logic next_valid;
		if (!arst_n) begin
			value_valid <= 1'b0;
		end else begin
			next_valid = value_valid;
			if (value_valid && value_ready) begin
				predict_text(value);
				values_sent++;
				next_valid = 1'b0;
			end
			// valid is raised only once the previous item is gone, so it never drops early
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_values.size() != 0) begin
					value      <= pending_values.pop_front();
					next_valid = 1'b1;
					gap_left   = draw_pause();
				end
			end
			value_valid <= next_valid;
		end
	end

	// output side: random back-pressure
	always @(posedge clk) begin : drive_ready
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				stall_left = draw_pause();
			end
		end
	end

	// each accepted character against the oldest expectation
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && result_valid && result_ready) begin
			chars_seen++;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected character %h last %b", character, last));
			end else begin
				want = expected_text.pop_front();
				if (character !== want.ch) begin
					report_mismatch($sformatf("character %h, want %h", character, want.ch));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %b, want %b", last, want.last));
				end
			end
		end
	end

	// ends a hung run: no handshake on either side for too long
	always @(posedge clk) begin : watchdog
		if ((value_valid && value_ready) || (result_valid && result_ready) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		logic [itrd_pkg::CFG_W-1:0] data;
		logic [4:0]                 count;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: radix two and an all-zero alphabet
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(32'hffffffff);
		pending_values.push_back(MOST_NEG);
		pending_values.push_back(MOST_POS);
		settle();
		settings_used++;

		// hex with a readable alphabet, count written with junk above bit 4
		write_reg(itrd_pkg::REG_SYMBOLS_LOW, HEX_LO);
		write_reg(itrd_pkg::REG_SYMBOLS_HIGH, HEX_HI);
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'hffffffff_ffffffe0 | 64'd16);
		pending_values.push_back(32'd0);
		pending_values.push_back(MOST_POS);
		pending_values.push_back(MOST_NEG);
		pending_values.push_back(32'hffffffff);
		pending_values.push_back(32'd15);
		pending_values.push_back(32'd16);
		pending_values.push_back(-32'sd16);
		pending_values.push_back(32'h12345678);
		settle();
		settings_used++;

		// decimal
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'd10);
		pending_values.push_back(32'd9);
		pending_values.push_back(32'd10);
		pending_values.push_back(-32'sd99);
		pending_values.push_back(MOST_NEG);
		settle();
		settings_used++;

		// count of zero falls back to two; repeated and zero symbol bytes
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'hffffffff_ffffffe0);
		write_reg(itrd_pkg::REG_SYMBOLS_LOW, 64'h31003100_31003100);
		pending_values.push_back(32'd5);
		pending_values.push_back(-32'sd5);
		settle();
		// count of one also falls back to two
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'd1);
		pending_values.push_back(32'd6);
		settle();
		// counts above the limit clamp to sixteen
		write_reg(itrd_pkg::REG_SYMBOLS_LOW, HEX_LO);
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'd31);
		pending_values.push_back(32'hdeadbeef);
		settle();
		write_reg(itrd_pkg::REG_SYMBOL_COUNT, 64'd17);
		// a write to the spare index must leave the radix at sixteen
		write_reg(REG_SPARE, 64'h3);
		pending_values.push_back(32'hffffffff);
		pending_values.push_back(32'd255);
		settle();
		settings_used += 4;

		// random settings, the extremes first
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: count = 5'd2;
				1: count = 5'd16;
				2: count = 5'd31;
				default: count = 5'($urandom_range(0, 31));
			endcase
			data = {$urandom, $urandom};
			data[itrd_pkg::COUNT_W-1:0] = count;
			write_reg(itrd_pkg::REG_SYMBOL_COUNT, data);
			if ($urandom_range(0, 2) != 0) begin
				write_reg(itrd_pkg::REG_SYMBOLS_LOW, {$urandom, $urandom});
				write_reg(itrd_pkg::REG_SYMBOLS_HIGH, {$urandom, $urandom});
			end else begin
				write_reg(itrd_pkg::REG_SYMBOLS_LOW, HEX_LO);
				write_reg(itrd_pkg::REG_SYMBOLS_HIGH, HEX_HI);
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_SPARE, {$urandom, $urandom});
			end
			steady = (ph % 4 == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pending_values.push_back(pick_value());
			end
			settle();
			settings_used++;
		end

		$display("sent %0d values and checked %0d characters over %0d register settings",
			values_sent, chars_seen, settings_used);
		$display("radix clamping, signs, extremes and random alphabets all exercised");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== int_to_radix_digit_string.f =====
rtl/itrd_pkg.sv
rtl/itrd_div.sv
rtl/int_to_radix_digit_string.sv
sim/tb_int_to_radix_digit_string.sv
